[rtl/brs_pkg.sv]
// shared constants, types and helpers of the bilinear image resampler
package brs_pkg;

	// build-time sizes of the frame store and the weight precision
	localparam int MAX_SRC_WIDTH  = 512;
	localparam int MAX_SRC_HEIGHT = 512;
	localparam int MAX_PLANES     = 4;
	localparam int WEIGHT_BITS    = 8;

	// field and register widths
	localparam int SRC_CFG_W  = 10;
	localparam int DST_CFG_W  = 13;
	localparam int PC_W       = 3;
	localparam int PLANE_W    = 2;
	localparam int POS_W      = 12;
	localparam int SAMPLE_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int DEST_LIMIT = 4096;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANES     = 3'd4;

	// largest source sizes the 10-bit registers can reach
	localparam int SRC_REG_MAX = (1 << SRC_CFG_W) - 1;
	localparam int SW_MAX = (MAX_SRC_WIDTH < SRC_REG_MAX) ? MAX_SRC_WIDTH : SRC_REG_MAX;
	localparam int SH_MAX = (MAX_SRC_HEIGHT < SRC_REG_MAX) ? MAX_SRC_HEIGHT : SRC_REG_MAX;
	localparam int AX_MAX = (SW_MAX > SH_MAX) ? SW_MAX : SH_MAX;

	// reset values, saturated to the build sizes
	localparam logic [SRC_CFG_W-1:0] SW_RESET = SRC_CFG_W'((512 < SW_MAX) ? 512 : SW_MAX);
	localparam logic [SRC_CFG_W-1:0] SH_RESET = SRC_CFG_W'((512 < SH_MAX) ? 512 : SH_MAX);
	localparam logic [DST_CFG_W-1:0] DW_RESET = DST_CFG_W'(512);
	localparam logic [DST_CFG_W-1:0] DH_RESET = DST_CFG_W'(512);
	localparam logic [PC_W-1:0] NP_RESET = PC_W'((3 < MAX_PLANES) ? 3 : MAX_PLANES);

	// axis mapping: position t, divisor 2*dst, quotient = index and weight bits
	localparam int IDX_W = $clog2(AX_MAX);
	localparam int T_W   = POS_W + 1 + SRC_CFG_W;
	localparam int DEN_W = DST_CFG_W + 1;
	localparam int Q_W   = IDX_W + WEIGHT_BITS;
	localparam int AX_LAT = Q_W + 3;

	// frame store banked by column and row parity
	localparam int XI_W = $clog2(SW_MAX);
	localparam int YI_W = $clog2(SH_MAX);
	localparam int XH_W = (XI_W > 1) ? XI_W - 1 : 1;
	localparam int YH_W = (YI_W > 1) ? YI_W - 1 : 1;
	localparam int ADDR_W = PLANE_W + YH_W + XH_W;
	localparam int BANK_DEPTH = 1 << ADDR_W;

	// blend widths
	localparam int TOP_W = SAMPLE_W + WEIGHT_BITS;
	localparam int ACC_W = SAMPLE_W + 2 * WEIGHT_BITS;

	// write into one bank
	typedef struct packed {
		logic                  vld;
		logic [1:0]            bank;
		logic [ADDR_W-1:0]     addr;
		logic [SAMPLE_W-1:0]   data;
	} wr_req_t;

	// control that travels beside the axis pipeline
	typedef struct packed {
		logic                  vld;
		logic                  rd;
		logic                  err;
		logic                  wr_ok;
		logic [PLANE_W-1:0]    plane;
		logic [1:0]            wbank;
		logic [ADDR_W-1:0]     waddr;
		logic [SAMPLE_W-1:0]   wdata;
	} ctl_t;

	// saturate a size into 1..hi
	function automatic logic [DST_CFG_W-1:0] clamp_size(input logic [DST_CFG_W-1:0] v,
			input logic [DST_CFG_W-1:0] hi);
		logic [DST_CFG_W-1:0] r;
		r = v;
		if (v == '0) r = DST_CFG_W'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

[rtl/brs_if.sv]
// request, result and configuration channels of the resampler

interface brs_req_if;
	import brs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [PLANE_W-1:0]    plane;
	logic [POS_W-1:0]      pos_x;
	logic [POS_W-1:0]      pos_y;
	logic [SAMPLE_W-1:0]   sample_in;
	modport source (output valid, action, plane, pos_x, pos_y, sample_in, input ready);
	modport sink (input valid, action, plane, pos_x, pos_y, sample_in, output ready);
endinterface

interface brs_rsp_if;
	import brs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [SAMPLE_W-1:0]   out_value;
	logic                  range_error;
	modport source (output valid, out_value, range_error, input ready);
	modport sink (input valid, out_value, range_error, output ready);
endinterface

interface brs_cfg_if;
	import brs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/brs_axis.sv]
// one axis: source position, bit-per-stage division, clamped neighbour indices
module brs_axis (
	input  logic                           clk,
	input  logic                           en,
	input  logic [brs_pkg::POS_W-1:0]      d,
	input  logic [brs_pkg::SRC_CFG_W-1:0]  src_size,
	input  logic [brs_pkg::DST_CFG_W-1:0]  dst_size,
	output logic [brs_pkg::IDX_W-1:0]      idx0,
	output logic [brs_pkg::IDX_W-1:0]      idx1,
	output logic [brs_pkg::WEIGHT_BITS-1:0] weight
);
	import brs_pkg::*;

	logic [T_W-1:0]         prod_s1;
	logic [T_W:0]           t_full;
	logic [T_W-1:0]         t_hi;
	logic [DEN_W-1:0]       den;
	logic [DEN_W-1:0]       div_rem_s [Q_W+1];
	logic [Q_W-1:0]         div_qn_s [Q_W+1];
	logic                   div_neg_s [Q_W+1];
	logic [DEN_W-1:0]       rem_nx [Q_W];
	logic [Q_W-1:0]         qn_nx [Q_W];
	logic [IDX_W-1:0]       q;
	logic [SRC_CFG_W-1:0]   lim;
	logic [SRC_CFG_W:0]     q_e;
	logic [SRC_CFG_W:0]     q1_e;
	logic [SRC_CFG_W:0]     lim_e;
	logic [IDX_W-1:0]       idx0_s3;
	logic [IDX_W-1:0]       idx1_s3;
	logic [WEIGHT_BITS-1:0] weight_s3;

	// (2d+1) * src
	always_ff @(posedge clk) begin
		if (en) prod_s1 <= T_W'({d, 1'b1}) * T_W'(src_size);
	end

	// t = (2d+1)*src - dst, divisor 2*dst
	assign t_full = {1'b0, prod_s1} - (T_W+1)'(dst_size);
	assign t_hi   = t_full[T_W-1:0] >> IDX_W;
	assign den    = {dst_size, 1'b0};

	// one quotient bit per stage, numerator bits shift out as quotient bits shift in
	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			logic [DEN_W:0] trial;
			trial = {div_rem_s[k], div_qn_s[k][Q_W-1]};
			if (trial >= {1'b0, den}) begin
				rem_nx[k] = DEN_W'(trial - {1'b0, den});
				qn_nx[k]  = {div_qn_s[k][Q_W-2:0], 1'b1};
			end else begin
				rem_nx[k] = trial[DEN_W-1:0];
				qn_nx[k]  = {div_qn_s[k][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_s[0] <= t_hi[DEN_W-1:0];
			div_qn_s[0]  <= {t_full[IDX_W-1:0], {WEIGHT_BITS{1'b0}}};
			div_neg_s[0] <= t_full[T_W];
			for (int k = 0; k < Q_W; k++) begin
				div_rem_s[k+1] <= rem_nx[k];
				div_qn_s[k+1]  <= qn_nx[k];
				div_neg_s[k+1] <= div_neg_s[k];
			end
		end
	end

	// clamp to the source image, negative positions pin to index 0
	assign q     = div_qn_s[Q_W][Q_W-1:WEIGHT_BITS];
	assign lim   = src_size - SRC_CFG_W'(1);
	assign q_e   = (SRC_CFG_W+1)'(q);
	assign q1_e  = q_e + (SRC_CFG_W+1)'(1);
	assign lim_e = {1'b0, lim};

	always_ff @(posedge clk) begin
		if (en) begin
			if (div_neg_s[Q_W]) begin
				idx0_s3   <= '0;
				idx1_s3   <= '0;
				weight_s3 <= '0;
			end else begin
				idx0_s3   <= (q_e > lim_e) ? IDX_W'(lim) : q;
				idx1_s3   <= (q1_e > lim_e) ? IDX_W'(lim) : IDX_W'(q1_e);
				weight_s3 <= div_qn_s[Q_W][WEIGHT_BITS-1:0];
			end
		end
	end

	assign idx0   = idx0_s3;
	assign idx1   = idx1_s3;
	assign weight = weight_s3;

endmodule

[rtl/brs_store.sv]
// frame store in four parity banks, one write and four reads per cycle while en is high
module brs_store (
	input  logic                                    clk,
	input  logic                                    en,
	input  brs_pkg::wr_req_t                        wr,
	input  logic [3:0][brs_pkg::ADDR_W-1:0]         rd_addr,
	output logic [3:0][brs_pkg::SAMPLE_W-1:0]       rd_data
);
	import brs_pkg::*;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [SAMPLE_W-1:0] mem [BANK_DEPTH];
		logic [SAMPLE_W-1:0] rd_q;

		// a read returns the data held before a write in the same cycle; read data registered
		always_ff @(posedge clk) begin
			if (en) begin
				if (wr.vld && wr.bank == 2'(b)) mem[wr.addr] <= wr.data;
				rd_q <= mem[rd_addr[b]];
			end
		end

		assign rd_data[b] = rd_q;
	end

endmodule

[rtl/brs_blend.sv]
// two-stage bilinear blend: horizontal pair blends, then vertical blend
module brs_blend (
	input  logic                                clk,
	input  logic                                en,
	input  logic [brs_pkg::SAMPLE_W-1:0]        v00,
	input  logic [brs_pkg::SAMPLE_W-1:0]        v10,
	input  logic [brs_pkg::SAMPLE_W-1:0]        v01,
	input  logic [brs_pkg::SAMPLE_W-1:0]        v11,
	input  logic [brs_pkg::WEIGHT_BITS-1:0]     wx,
	input  logic [brs_pkg::WEIGHT_BITS-1:0]     wy,
	output logic [brs_pkg::ACC_W-1:0]           acc
);
	import brs_pkg::*;

	localparam logic [WEIGHT_BITS:0] ONE = (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;

	logic [WEIGHT_BITS:0]   wxc;
	logic [WEIGHT_BITS:0]   wyc;
	logic [TOP_W-1:0]       top_s1;
	logic [TOP_W-1:0]       bot_s1;
	logic [WEIGHT_BITS-1:0] wy_s1;
	logic [ACC_W-1:0]       acc_s2;

	assign wxc = ONE - (WEIGHT_BITS+1)'(wx);
	assign wyc = ONE - (WEIGHT_BITS+1)'(wy_s1);

	// row blends
	always_ff @(posedge clk) begin
		if (en) begin
			top_s1 <= TOP_W'(TOP_W'(v00) * TOP_W'(wxc) + TOP_W'(v10) * TOP_W'(wx));
			bot_s1 <= TOP_W'(TOP_W'(v01) * TOP_W'(wxc) + TOP_W'(v11) * TOP_W'(wx));
			wy_s1  <= wy;
		end
	end

	// column blend
	always_ff @(posedge clk) begin
		if (en) acc_s2 <= ACC_W'(top_s1) * ACC_W'(wyc) + ACC_W'(bot_s1) * ACC_W'(wy_s1);
	end

	assign acc = acc_s2;

endmodule

[rtl/bilinear_image_resampler.sv]
// top level: configuration, control pipeline, axis units, frame store, blend, output register

// Bilinear resampler with half-pixel centers over a planar frame store. Write items
// store one sample; read items return one interpolated sample or a range error. One
// item enters per clock unless the pipeline is held. A read passes the axis units,
// whose depth is set by the per-axis divider that retires one quotient bit per stage,
// then the store read, the blend and the output register. The whole pipeline holds
// while a result waits at the output. The store is split into four banks by column
// and row parity, so the four neighbours of a read come out in the same cycle. Writes
// take effect in item order with the reads around them. Configuration must be written
// by the user only while no item is in flight; the block does not enforce this.
module bilinear_image_resampler (
	input  logic      clk,
	input  logic      arst_n,
	brs_req_if.sink   req,
	brs_rsp_if.source rsp,
	brs_cfg_if.sink   cfg
);
	import brs_pkg::*;

	logic [SRC_CFG_W-1:0]   sw_q;
	logic [SRC_CFG_W-1:0]   sh_q;
	logic [DST_CFG_W-1:0]   dw_q;
	logic [DST_CFG_W-1:0]   dh_q;
	logic [PC_W-1:0]        np_q;
	logic                   en;
	ctl_t                   ctl_in;
	ctl_t                   dl_s [AX_LAT+1];
	logic [POS_W-1:0]       px_s1;
	logic [POS_W-1:0]       py_s1;
	logic [IDX_W-1:0]       ax_x0;
	logic [IDX_W-1:0]       ax_x1;
	logic [IDX_W-1:0]       ax_y0;
	logic [IDX_W-1:0]       ax_y1;
	logic [WEIGHT_BITS-1:0] ax_wx;
	logic [WEIGHT_BITS-1:0] ax_wy;
	ctl_t                   ctl_a;
	wr_req_t                wr;
	logic [3:0][ADDR_W-1:0] rd_addr;
	logic [3:0][SAMPLE_W-1:0] rd_data;
	ctl_t                   c_s2;
	ctl_t                   c_s3;
	ctl_t                   c_s4;
	logic [WEIGHT_BITS-1:0] wx_s2;
	logic [WEIGHT_BITS-1:0] wy_s2;
	logic [1:0]             b00_s2;
	logic [1:0]             b10_s2;
	logic [1:0]             b01_s2;
	logic [1:0]             b11_s2;
	logic [ACC_W-1:0]       acc;
	logic [ACC_W:0]         rsum;
	logic [ACC_W:0]         rshift;
	logic                   ov_q;
	logic                   oe_q;
	logic [SAMPLE_W-1:0]    val_q;

	// configuration registers, held saturated
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SW_RESET;
			sh_q <= SH_RESET;
			dw_q <= DW_RESET;
			dh_q <= DH_RESET;
			np_q <= NP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SRC_WIDTH: sw_q <= SRC_CFG_W'(clamp_size(
					DST_CFG_W'(cfg.data[SRC_CFG_W-1:0]), DST_CFG_W'(SW_MAX)));
				CFG_SRC_HEIGHT: sh_q <= SRC_CFG_W'(clamp_size(
					DST_CFG_W'(cfg.data[SRC_CFG_W-1:0]), DST_CFG_W'(SH_MAX)));
				CFG_DST_WIDTH: dw_q <= clamp_size(cfg.data, DST_CFG_W'(DEST_LIMIT));
				CFG_DST_HEIGHT: dh_q <= clamp_size(cfg.data, DST_CFG_W'(DEST_LIMIT));
				CFG_PLANES: np_q <= PC_W'(clamp_size(
					DST_CFG_W'(cfg.data[PC_W-1:0]), DST_CFG_W'(MAX_PLANES)));
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or being taken
	assign en        = !ov_q || rsp.ready;
	assign req.ready = en;

	// classify the incoming item and form its write address
	always_comb begin
		ctl_in.vld   = req.valid;
		ctl_in.rd    = req.action;
		ctl_in.err   = req.action && ((PC_W'(req.plane) >= np_q)
			|| (DST_CFG_W'(req.pos_x) >= dw_q) || (DST_CFG_W'(req.pos_y) >= dh_q));
		ctl_in.wr_ok = (PC_W'(req.plane) < np_q)
			&& (req.pos_x < POS_W'(sw_q)) && (req.pos_y < POS_W'(sh_q));
		ctl_in.plane = req.plane;
		ctl_in.wbank = {req.pos_y[0], req.pos_x[0]};
		ctl_in.waddr = {req.plane, YH_W'(req.pos_y >> 1), XH_W'(req.pos_x >> 1)};
		ctl_in.wdata = req.sample_in;
	end

	// control delay line alongside the axis units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= AX_LAT; k++) dl_s[k] <= '0;
		end else if (en) begin
			dl_s[0] <= ctl_in;
			for (int k = 0; k < AX_LAT; k++) dl_s[k+1] <= dl_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= req.pos_x;
			py_s1 <= req.pos_y;
		end
	end

	brs_axis u_axis_x (
		.clk      (clk),
		.en       (en),
		.d        (px_s1),
		.src_size (sw_q),
		.dst_size (dw_q),
		.idx0     (ax_x0),
		.idx1     (ax_x1),
		.weight   (ax_wx)
	);

	brs_axis u_axis_y (
		.clk      (clk),
		.en       (en),
		.d        (py_s1),
		.src_size (sh_q),
		.dst_size (dh_q),
		.idx0     (ax_y0),
		.idx1     (ax_y1),
		.weight   (ax_wy)
	);

	assign ctl_a = dl_s[AX_LAT];

	// write transfer reaches the store in item order with the reads
	assign wr.vld  = ctl_a.vld && !ctl_a.rd && ctl_a.wr_ok;
	assign wr.bank = ctl_a.wbank;
	assign wr.addr = ctl_a.waddr;
	assign wr.data = ctl_a.wdata;

	// per bank, pick the neighbour column and row of matching parity
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			logic [IDX_W-1:0] col;
			logic [IDX_W-1:0] row;
			col = (ax_x0[0] == b[0]) ? ax_x0 : ax_x1;
			row = (ax_y0[0] == b[1]) ? ax_y0 : ax_y1;
			rd_addr[b] = {ctl_a.plane, YH_W'(row >> 1), XH_W'(col >> 1)};
		end
	end

	brs_store u_store (
		.clk     (clk),
		.en      (en),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stage beside the store read: weights and bank of each neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s2 <= '0;
			c_s3 <= '0;
			c_s4 <= '0;
		end else if (en) begin
			c_s2 <= ctl_a;
			c_s3 <= c_s2;
			c_s4 <= c_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s2  <= ax_wx;
			wy_s2  <= ax_wy;
			b00_s2 <= {ax_y0[0], ax_x0[0]};
			b10_s2 <= {ax_y0[0], ax_x1[0]};
			b01_s2 <= {ax_y1[0], ax_x0[0]};
			b11_s2 <= {ax_y1[0], ax_x1[0]};
		end
	end

	brs_blend u_blend (
		.clk (clk),
		.en  (en),
		.v00 (rd_data[b00_s2]),
		.v10 (rd_data[b10_s2]),
		.v01 (rd_data[b01_s2]),
		.v11 (rd_data[b11_s2]),
		.wx  (wx_s2),
		.wy  (wy_s2),
		.acc (acc)
	);

	// round half up and saturate
	assign rsum   = {1'b0, acc} + ((ACC_W+1)'(1) << (2 * WEIGHT_BITS - 1));
	assign rshift = rsum >> (2 * WEIGHT_BITS);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (en) ov_q <= c_s4.vld && c_s4.rd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oe_q <= c_s4.err;
			if (c_s4.err) val_q <= '0;
			else if (rshift > (ACC_W+1)'({SAMPLE_W{1'b1}})) val_q <= '1;
			else val_q <= rshift[SAMPLE_W-1:0];
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.out_value   = val_q;
	assign rsp.range_error = oe_q;

`ifndef NO_ASSERTIONS
	// a range error always carries a zero sample
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && oe_q |-> val_q == '0)
		else $error("range error with nonzero sample");

	// horizontal neighbours are equal or adjacent
	a_x_adjacent: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_a.vld && ctl_a.rd && !ctl_a.err
			|-> (ax_x1 == ax_x0) || (ax_x1 == ax_x0 + IDX_W'(1)))
		else $error("horizontal neighbours not adjacent");

	// neighbour indices stay inside the source image
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_a.vld && ctl_a.rd && !ctl_a.err
			|-> (SRC_CFG_W'(ax_x1) < sw_q) && (SRC_CFG_W'(ax_y1) < sh_q))
		else $error("neighbour index outside source image");
`endif

endmodule
